// ===== design/assert_macros.svh =====
// assertion helpers, clocked on clock and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge
`define STT_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define STT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/stt_pkg.sv =====
package stt_pkg;

   localparam int OFFSET_BITS = 20;
   localparam int LINE_BITS   = 16;
   localparam int KIND_BITS   = 5;
   localparam int TOK_SLOTS   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_BITS-1:0] KIND_LPAREN       = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN       = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE       = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE       = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_COMMA        = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_DOT          = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_MINUS        = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_PLUS         = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_SEMICOLON    = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_SLASH        = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_STAR         = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_BANG         = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_BANG_EQUAL   = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL        = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL_EQUAL  = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_GREATER      = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_GREATER_EQ   = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_LESS         = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_LESS_EQ      = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_STRING       = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER       = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_IDENT        = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_EOF          = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_UNEXPECTED   = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_UNTERMINATED = 5'd24;

   localparam logic [2:0] OP_BANG    = 3'd0;
   localparam logic [2:0] OP_EQUAL   = 3'd1;
   localparam logic [2:0] OP_LESS    = 3'd2;
   localparam logic [2:0] OP_GREATER = 3'd3;
   localparam logic [2:0] OP_SLASH   = 3'd4;

   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_GREATER    = 8'h3E;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   typedef enum logic [7:0] {
      MODE_IDLE    = 8'b0000_0001,
      MODE_OPER    = 8'b0000_0010,
      MODE_COMMENT = 8'b0000_0100,
      MODE_STRING  = 8'b0000_1000,
      MODE_INT     = 8'b0001_0000,
      MODE_DOT     = 8'b0010_0000,
      MODE_FRAC    = 8'b0100_0000,
      MODE_IDENT   = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   token_kind;
      logic [OFFSET_BITS-1:0] token_start;
      logic [OFFSET_BITS-1:0] token_length;
      logic [LINE_BITS-1:0]   line_number;
      logic                   last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] length;
   } tok_type;

   // tokens caused by one input transfer, all on the same line
   typedef struct packed {
      logic [1:0]                count;
      logic [LINE_BITS-1:0]      line;
      tok_type [TOK_SLOTS-1:0]   toks;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic [KIND_BITS-1:0] op_single(input logic [2:0] op);
      logic [KIND_BITS-1:0] k;
      case (op)
         OP_BANG:    k = KIND_BANG;
         OP_EQUAL:   k = KIND_EQUAL;
         OP_LESS:    k = KIND_LESS;
         OP_GREATER: k = KIND_GREATER;
         default:    k = KIND_SLASH;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_BITS-1:0] op_double(input logic [2:0] op);
      logic [KIND_BITS-1:0] k;
      case (op)
         OP_BANG:    k = KIND_BANG_EQUAL;
         OP_EQUAL:   k = KIND_EQUAL_EQUAL;
         OP_LESS:    k = KIND_LESS_EQ;
         OP_GREATER: k = KIND_GREATER_EQ;
         default:    k = KIND_SLASH;
      endcase
      return k;
   endfunction

endpackage

// ===== design/stt_front.sv =====
module stt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  stt_pkg::req_type    req_data,
   output logic                req_stall,
   input  stt_pkg::qstat_type  qstat,
   output logic                push,
   output stt_pkg::bundle_type push_data
);

   stt_pkg::mode_type                 mode_ff, mode_in;
   logic [2:0]                        op_ff, op_in;
   logic [stt_pkg::OFFSET_BITS-1:0]   begin_ff, begin_in;
   logic [stt_pkg::OFFSET_BITS-1:0]   offset_ff, offset_in;
   logic [stt_pkg::LINE_BITS-1:0]     line_ff, line_in;

   logic                              accept;
   logic [7:0]                        c;
   logic [stt_pkg::OFFSET_BITS-1:0]   len;
   logic [1:0]                        n;
   stt_pkg::tok_type [stt_pkg::TOK_SLOTS-1:0] toks;
   logic                              flush, rescan, eof, line_step;

   assign accept    = req_valid && !qstat.full;
   assign req_stall = qstat.full;
   assign c         = req_data.char_byte;
   assign len       = offset_ff - begin_ff;

   always_comb begin
      n         = 2'd0;
      toks      = '0;
      mode_in   = mode_ff;
      op_in     = op_ff;
      begin_in  = begin_ff;
      flush     = 1'b0;
      rescan    = 1'b0;
      eof       = 1'b0;
      line_step = 1'b0;

      if (req_data.end_of_source) begin
         flush = 1'b1;
         eof   = 1'b1;
      end else begin
         case (mode_ff)
            stt_pkg::MODE_OPER: begin
               if (op_ff != stt_pkg::OP_SLASH && c == stt_pkg::CH_EQUAL) begin
                  toks[n].kind   = stt_pkg::op_double(op_ff);
                  toks[n].start  = begin_ff;
                  toks[n].length = stt_pkg::OFFSET_BITS'(2);
                  n              = n + 2'd1;
                  mode_in        = stt_pkg::MODE_IDLE;
               end else if (op_ff == stt_pkg::OP_SLASH && c == stt_pkg::CH_SLASH) begin
                  mode_in = stt_pkg::MODE_COMMENT;
               end else begin
                  flush  = 1'b1;
                  rescan = 1'b1;
               end
            end
            stt_pkg::MODE_COMMENT: begin
               if (c == stt_pkg::CH_NEWLINE) begin
                  mode_in   = stt_pkg::MODE_IDLE;
                  line_step = 1'b1;
               end
            end
            stt_pkg::MODE_STRING: begin
               if (c == stt_pkg::CH_QUOTE) begin
                  toks[n].kind   = stt_pkg::KIND_STRING;
                  toks[n].start  = begin_ff;
                  toks[n].length = len + stt_pkg::OFFSET_BITS'(1);
                  n              = n + 2'd1;
                  mode_in        = stt_pkg::MODE_IDLE;
               end else if (c == stt_pkg::CH_NEWLINE) begin
                  line_step = 1'b1;
               end
            end
            stt_pkg::MODE_INT: begin
               if (c == stt_pkg::CH_DOT) begin
                  mode_in = stt_pkg::MODE_DOT;
               end else if (!stt_pkg::is_digit(c)) begin
                  flush  = 1'b1;
                  rescan = 1'b1;
               end
            end
            stt_pkg::MODE_DOT: begin
               if (stt_pkg::is_digit(c)) begin
                  mode_in = stt_pkg::MODE_FRAC;
               end else begin
                  flush  = 1'b1;
                  rescan = 1'b1;
               end
            end
            stt_pkg::MODE_FRAC: begin
               if (!stt_pkg::is_digit(c)) begin
                  flush  = 1'b1;
                  rescan = 1'b1;
               end
            end
            stt_pkg::MODE_IDENT: begin
               if (!stt_pkg::is_digit(c) && !stt_pkg::is_alpha(c)) begin
                  flush  = 1'b1;
                  rescan = 1'b1;
               end
            end
            default: begin
               rescan = 1'b1;
            end
         endcase
      end

      // pending token that ends just before this byte
      if (flush) begin
         case (mode_ff)
            stt_pkg::MODE_OPER: begin
               toks[n].kind   = stt_pkg::op_single(op_ff);
               toks[n].start  = begin_ff;
               toks[n].length = stt_pkg::OFFSET_BITS'(1);
               n              = n + 2'd1;
            end
            stt_pkg::MODE_STRING: begin
               toks[n].kind   = stt_pkg::KIND_UNTERMINATED;
               toks[n].start  = begin_ff;
               toks[n].length = len;
               n              = n + 2'd1;
            end
            stt_pkg::MODE_INT, stt_pkg::MODE_FRAC: begin
               toks[n].kind   = stt_pkg::KIND_NUMBER;
               toks[n].start  = begin_ff;
               toks[n].length = len;
               n              = n + 2'd1;
            end
            stt_pkg::MODE_DOT: begin
               toks[n].kind   = stt_pkg::KIND_NUMBER;
               toks[n].start  = begin_ff;
               toks[n].length = len - stt_pkg::OFFSET_BITS'(1);
               n              = n + 2'd1;
               toks[n].kind   = stt_pkg::KIND_DOT;
               toks[n].start  = offset_ff - stt_pkg::OFFSET_BITS'(1);
               toks[n].length = stt_pkg::OFFSET_BITS'(1);
               n              = n + 2'd1;
            end
            stt_pkg::MODE_IDENT: begin
               toks[n].kind   = stt_pkg::KIND_IDENT;
               toks[n].start  = begin_ff;
               toks[n].length = len;
               n              = n + 2'd1;
            end
            default: begin
            end
         endcase
         mode_in = stt_pkg::MODE_IDLE;
      end

      if (eof) begin
         toks[n].kind   = stt_pkg::KIND_EOF;
         toks[n].start  = offset_ff;
         toks[n].length = '0;
         n              = n + 2'd1;
         mode_in        = stt_pkg::MODE_IDLE;
         op_in          = stt_pkg::OP_BANG;
         begin_in       = '0;
      end else if (rescan) begin
         mode_in = stt_pkg::MODE_IDLE;
         case (c)
            stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_LBRACE,
            stt_pkg::CH_RBRACE, stt_pkg::CH_COMMA, stt_pkg::CH_DOT,
            stt_pkg::CH_MINUS, stt_pkg::CH_PLUS, stt_pkg::CH_SEMICOLON,
            stt_pkg::CH_STAR: begin
               case (c)
                  stt_pkg::CH_LPAREN:    toks[n].kind = stt_pkg::KIND_LPAREN;
                  stt_pkg::CH_RPAREN:    toks[n].kind = stt_pkg::KIND_RPAREN;
                  stt_pkg::CH_LBRACE:    toks[n].kind = stt_pkg::KIND_LBRACE;
                  stt_pkg::CH_RBRACE:    toks[n].kind = stt_pkg::KIND_RBRACE;
                  stt_pkg::CH_COMMA:     toks[n].kind = stt_pkg::KIND_COMMA;
                  stt_pkg::CH_DOT:       toks[n].kind = stt_pkg::KIND_DOT;
                  stt_pkg::CH_MINUS:     toks[n].kind = stt_pkg::KIND_MINUS;
                  stt_pkg::CH_PLUS:      toks[n].kind = stt_pkg::KIND_PLUS;
                  stt_pkg::CH_SEMICOLON: toks[n].kind = stt_pkg::KIND_SEMICOLON;
                  default:               toks[n].kind = stt_pkg::KIND_STAR;
               endcase
               toks[n].start  = offset_ff;
               toks[n].length = stt_pkg::OFFSET_BITS'(1);
               n              = n + 2'd1;
            end
            stt_pkg::CH_BANG: begin
               op_in    = stt_pkg::OP_BANG;
               mode_in  = stt_pkg::MODE_OPER;
               begin_in = offset_ff;
            end
            stt_pkg::CH_EQUAL: begin
               op_in    = stt_pkg::OP_EQUAL;
               mode_in  = stt_pkg::MODE_OPER;
               begin_in = offset_ff;
            end
            stt_pkg::CH_LESS: begin
               op_in    = stt_pkg::OP_LESS;
               mode_in  = stt_pkg::MODE_OPER;
               begin_in = offset_ff;
            end
            stt_pkg::CH_GREATER: begin
               op_in    = stt_pkg::OP_GREATER;
               mode_in  = stt_pkg::MODE_OPER;
               begin_in = offset_ff;
            end
            stt_pkg::CH_SLASH: begin
               op_in    = stt_pkg::OP_SLASH;
               mode_in  = stt_pkg::MODE_OPER;
               begin_in = offset_ff;
            end
            stt_pkg::CH_SPACE, stt_pkg::CH_CR, stt_pkg::CH_TAB: begin
            end
            stt_pkg::CH_NEWLINE: begin
               line_step = 1'b1;
            end
            stt_pkg::CH_QUOTE: begin
               mode_in  = stt_pkg::MODE_STRING;
               begin_in = offset_ff;
            end
            default: begin
               if (stt_pkg::is_digit(c)) begin
                  mode_in  = stt_pkg::MODE_INT;
                  begin_in = offset_ff;
               end else if (stt_pkg::is_alpha(c)) begin
                  mode_in  = stt_pkg::MODE_IDENT;
                  begin_in = offset_ff;
               end else begin
                  toks[n].kind   = stt_pkg::KIND_UNEXPECTED;
                  toks[n].start  = offset_ff;
                  toks[n].length = stt_pkg::OFFSET_BITS'(1);
                  n              = n + 2'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (eof) begin
         offset_in = '0;
         line_in   = stt_pkg::LINE_BITS'(1);
      end else begin
         offset_in = offset_ff + stt_pkg::OFFSET_BITS'(1);
         // saturating line count
         if (line_step && line_ff != '1) begin
            line_in = line_ff + stt_pkg::LINE_BITS'(1);
         end else begin
            line_in = line_ff;
         end
      end
   end

   assign push            = accept && (n != 2'd0);
   assign push_data.count = n;
   assign push_data.line  = line_ff;
   assign push_data.toks  = toks;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stt_pkg::MODE_IDLE;
         op_ff     <= stt_pkg::OP_BANG;
         begin_ff  <= '0;
         offset_ff <= '0;
         line_ff   <= stt_pkg::LINE_BITS'(1);
      end else if (accept) begin
         mode_ff   <= mode_in;
         op_ff     <= op_in;
         begin_ff  <= begin_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
      end
   end

endmodule

// ===== design/stt_queue.sv =====
module stt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stt_pkg::bundle_type push_data,
   input  logic                pop,
   output stt_pkg::bundle_type head,
   output stt_pkg::qstat_type  qstat
);

   stt_pkg::bundle_type              mem_ff [stt_pkg::QUEUE_DEPTH];
   logic [stt_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [stt_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [stt_pkg::QCNT_BITS-1:0]    count_ff, count_in;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == stt_pkg::QCNT_BITS'(stt_pkg::QUEUE_DEPTH));
   assign head        = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + stt_pkg::QPTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + stt_pkg::QPTR_BITS'(1) : rd_ptr_ff;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + stt_pkg::QCNT_BITS'(1);
         2'b01:   count_in = count_ff - stt_pkg::QCNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/stt_back.sv =====
module stt_back (
   input  logic                clock,
   input  logic                reset,
   input  stt_pkg::qstat_type  qstat,
   input  stt_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   output stt_pkg::rsp_type    rsp_data,
   input  logic                rsp_stall
);

   logic             valid_ff, valid_in;
   stt_pkg::rsp_type data_ff, data_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load, last;
   stt_pkg::tok_type tok;

   assign load = !qstat.empty && (!valid_ff || !rsp_stall);
   assign last = (idx_ff == head.count - 2'd1);
   assign pop  = load && last;
   assign tok  = head.toks[idx_ff];

   always_comb begin
      data_in              = data_ff;
      idx_in               = idx_ff;
      valid_in             = valid_ff && rsp_stall;
      if (load) begin
         data_in.token_kind   = tok.kind;
         data_in.token_start  = tok.start;
         data_in.token_length = tok.length;
         data_in.line_number  = head.line;
         data_in.last_of_run  = last;
         idx_in               = last ? 2'd0 : idx_ff + 2'd1;
         valid_in             = 1'b1;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== design/source_text_tokenizer.sv =====
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  stt_pkg::req_type (byte, end flag)
// rsp_      out        rsp_valid/rsp_stall  stt_pkg::rsp_type (one token)
// csr_      none
//
// one source byte is taken every cycle while req_stall is low; the scanner state updates as each byte is taken
// an item that yields k tokens gives them on the result port one token at a time (k at most 3)
// a four-entry token queue parts the scanner from the output register
// req_stall is high only while that queue is full; reset is synchronous, no clearing pass
`include "assert_macros.svh"

module source_text_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  stt_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output stt_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   stt_pkg::qstat_type  qstat;
   stt_pkg::bundle_type push_data;
   stt_pkg::bundle_type head;
   logic                push;
   logic                pop;
   logic                rsp_eof;
   logic                eof_ok;

   stt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   stt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   assign rsp_eof = rsp_valid && (rsp_data.token_kind == stt_pkg::KIND_EOF);
   assign eof_ok  = rsp_data.last_of_run && (rsp_data.token_length == '0);

   `STT_ASSERT_ALWAYS(a_queue_flags, !(qstat.empty && qstat.full), "queue empty and full")
   `STT_ASSERT_IMPLY(a_no_push_when_full, qstat.full, !push, "push into full queue")
   `STT_ASSERT_IMPLY(a_eof_last, rsp_eof, eof_ok, "eof token not last of run")

endmodule
